[design/msmf_pkg.sv]
package msmf_pkg;

    // Sizes of the filter.
    localparam int MAX_WINDOW  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int MAX_OUT     = (MAX_WINDOW + 1) / 2;
    localparam int SEEN_MAX    = 2 * MAX_WINDOW - 1;

    // Derived widths.
    localparam int CFG_W  = 6;
    localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
    localparam int HALF_W = $clog2(MAX_WINDOW / 2 + 1);
    localparam int SEEN_W = $clog2(SEEN_MAX + 1);
    localparam int REM_W  = $clog2(MAX_OUT + 1);
    localparam int POS_W  = 10;

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(5);

    // Output queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic signed [POS_W-1:0] pos_t;

    localparam pos_t POS_INF  = 10'sd300;
    localparam pos_t POS_NINF = -10'sd300;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_in;
    } item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] median;
        logic                          last_out;
    } result_t;

    // One rank request: the window contents with the weight of each tap.
    typedef struct packed {
        logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] vals;
        logic [MAX_WINDOW-1:0][WIN_W-1:0]       mult;
        logic [HALF_W-1:0]                      half;
        logic                                   last_out;
    } rank_req_t;

    // Number of positions shared by the window [a, b] and the span [x, y].
    function automatic logic [WIN_W-1:0] span_count(pos_t a, pos_t b, pos_t x, pos_t y);
        pos_t hi;
        pos_t lo;
        pos_t diff;
        hi = (b < y) ? b : y;
        lo = (a > x) ? a : x;
        diff = hi - lo + pos_t'(1);
        if (hi < lo)
        begin
            return '0;
        end
        return WIN_W'(diff);
    endfunction

    function automatic logic in_span(pos_t a, pos_t b, pos_t x);
        return (x >= a) && (x <= b);
    endfunction

    // Balanced adder tree; the terms never sum above MAX_WINDOW.
    function automatic logic [WIN_W-1:0] weight_sum(logic [MAX_WINDOW-1:0][WIN_W-1:0] terms);
        logic [MAX_WINDOW-1:0][WIN_W-1:0] acc;
        acc = terms;
        for (int s = MAX_WINDOW >> 1; s > 0; s = s >> 1)
        begin
            for (int i = 0; i < s; i++)
            begin
                acc[i] = acc[2*i] + acc[2*i+1];
            end
        end
        return acc[0];
    endfunction

endpackage

[design/msmf_rank.sv]
module msmf_rank
    import msmf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  rank_req_t req,
    output logic      res_valid,
    output result_t   res
);

    logic                                   s2_valid_reg;
    logic [MAX_WINDOW-1:0][WIN_W-1:0]       below_reg;
    logic [MAX_WINDOW-1:0][WIN_W-1:0]       below_next;
    logic [MAX_WINDOW-1:0][WIN_W-1:0]       upto_reg;
    logic [MAX_WINDOW-1:0][WIN_W-1:0]       upto_next;
    logic [MAX_WINDOW-1:0]                  present_reg;
    logic [MAX_WINDOW-1:0]                  present_next;
    logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] vals_reg;
    logic [HALF_W-1:0]                      half_reg;
    logic                                   last_reg;
    logic [SAMPLE_BITS-1:0]                 pick;

    // For every tap, the weight of all taps below it and of all taps not above it.
    always_comb
    begin
        logic [MAX_WINDOW-1:0][WIN_W-1:0] lt_terms;
        logic [MAX_WINDOW-1:0][WIN_W-1:0] le_terms;
        lt_terms = '0;
        le_terms = '0;
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            for (int t = 0; t < MAX_WINDOW; t++)
            begin
                lt_terms[t] = ($signed(req.vals[t]) < $signed(req.vals[j])) ? req.mult[t] : '0;
                le_terms[t] = ($signed(req.vals[t]) <= $signed(req.vals[j])) ? req.mult[t] : '0;
            end
            below_next[j]   = weight_sum(lt_terms);
            upto_next[j]    = weight_sum(le_terms);
            present_next[j] = (req.mult[j] != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid)
        begin
            below_reg   <= below_next;
            upto_reg    <= upto_next;
            present_reg <= present_next;
            vals_reg    <= req.vals;
            half_reg    <= req.half;
            last_reg    <= req.last_out;
        end
    end

    // The median is every tap whose value straddles the middle rank; all such taps
    // hold the same value, so they are simply ORed together.
    always_comb
    begin
        pick = '0;
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            if (present_reg[j] && (below_reg[j] <= WIN_W'(half_reg))
                && (upto_reg[j] > WIN_W'(half_reg)))
            begin
                pick = pick | vals_reg[j];
            end
        end
    end

    assign res_valid    = s2_valid_reg;
    assign res.median   = pick;
    assign res.last_out = last_reg;

endmodule

[design/msmf_out_fifo.sv]
module msmf_out_fifo
    import msmf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_word,
    output logic    pop_valid,
    input  logic    pop_stall,
    output result_t pop_word
);

    result_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic [FIFO_CNT_W-1:0]   count_next;
    logic                    pop;

    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && !pop_stall;
    assign pop_word  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

[design/mirrored_sliding_median_filter.sv]
// Channel   Direction  Handshake              Word
// item      in         item_valid/item_stall  item_t: sample, last_in
// result    out        result_valid/result_stall  result_t: median, last_out
// cfg       in         cfg_valid/cfg_ready    window_size (always ready)
//
// One item word is taken per clock. Results issue one per cycle through the
// single rank unit, so an item owing several, up to sixteen on a record's
// final word, holds the input until the last issues. A result is registered
// at issue and in the rank unit, then queued. Reset needs no clearing pass.
// A four-word output queue parts the two sides; results issue only while
// fewer than four are outstanding, so a stalled output eventually stalls input.
module mirrored_sliding_median_filter
    import msmf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] window_size
);

    // Configuration and the effective window geometry.
    logic [CFG_W-1:0]  window_size_reg;
    logic [WIN_W-1:0]  win_eff;
    logic [HALF_W-1:0] hl_eff;
    logic [WIN_W-1:0]  hr_eff;

    // Sample history: tap 0 is the newest sample of the record.
    logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] history_reg;

    // Record bookkeeping.
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_inc;
    logic [SEEN_W-1:0] n_new;
    logic [WIN_W-1:0]  owed_reg;
    logic [WIN_W-1:0]  owed_inc;
    logic [WIN_W-1:0]  owed_next;
    logic [WIN_W-1:0]  owed_cap;
    logic [WIN_W-1:0]  avail;
    logic [SEEN_W-1:0] k_first;
    logic [REM_W-1:0]  cnt_new;
    logic              blocked;

    // The job: the run of results owed by the last accepted word.
    logic [SEEN_W-1:0] job_n_reg;
    logic              job_end_reg;
    logic [WIN_W-1:0]  job_win_reg;
    logic [HALF_W-1:0] job_hl_reg;
    logic [SEEN_W-1:0] job_k_reg;
    logic [REM_W-1:0]  job_rem_reg;
    logic              job_last_reg;

    // Issue stage.
    logic [FIFO_CNT_W-1:0] credit_reg;
    logic                  issue;
    logic                  accept;
    logic                  pop;
    rank_req_t             s1_req_next;
    rank_req_t             s1_req_reg;
    logic                  s1_valid_reg;
    logic                  rank_valid;
    result_t               rank_word;

    assign cfg_ready = 1'b1;

    // A window of zero behaves as one, and anything past the history depth is
    // limited to it.
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (window_size_reg > CFG_W'(MAX_WINDOW))
        begin
            win_eff = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = WIN_W'(window_size_reg);
        end
        hl_eff = HALF_W'(win_eff >> 1);
        hr_eff = win_eff - WIN_W'(hl_eff);
    end

    // Results may issue only while the output queue is sure to have room.
    assign issue      = (job_rem_reg != '0) && (credit_reg < FIFO_CNT_W'(FIFO_DEPTH));
    assign item_stall = !((job_rem_reg == '0) || ((job_rem_reg == REM_W'(1)) && issue));
    assign accept     = item_valid && !item_stall;
    assign pop        = result_valid && !result_stall;

    // What the incoming word owes. Outputs are due once every sample of their
    // window has arrived; the final word of a record flushes all that remain.
    always_comb
    begin
        seen_inc = (seen_reg < SEEN_W'(SEEN_MAX)) ? seen_reg + SEEN_W'(1) : seen_reg;
        n_new    = seen_inc - SEEN_W'(1);
        owed_inc = (owed_reg < WIN_W'(MAX_WINDOW)) ? owed_reg + WIN_W'(1) : owed_reg;
        owed_cap = (owed_inc > WIN_W'(MAX_OUT)) ? WIN_W'(MAX_OUT) : owed_inc;
        avail    = (owed_inc >= hr_eff) ? owed_inc - hr_eff + WIN_W'(1) : '0;
        blocked  = 1'b0;
        if (item.last_in)
        begin
            k_first   = seen_inc - SEEN_W'(owed_cap);
            cnt_new   = REM_W'(owed_cap);
            owed_next = '0;
        end
        else
        begin
            k_first = seen_inc - SEEN_W'(owed_inc);
            // Near the record start the left mirror can reach past the newest
            // sample; then nothing is due yet.
            blocked = ((SEEN_W+1)'(k_first) + (SEEN_W+1)'(n_new)) < (SEEN_W+1)'(hl_eff);
            if (blocked)
            begin
                cnt_new = '0;
            end
            else if (avail > WIN_W'(MAX_OUT))
            begin
                cnt_new = REM_W'(MAX_OUT);
            end
            else
            begin
                cnt_new = REM_W'(avail);
            end
            owed_next = owed_inc - WIN_W'(cnt_new);
        end
    end

    // Tap weights for the result at position job_k. Each window position is
    // reflected about the record ends and then clamped into the history, so a
    // tap counts the positions that land on it. Interior taps have at most four
    // preimages; the oldest held tap and the newest tap also collect the
    // clamped tails.
    always_comb
    begin
        pos_t             n_p;
        pos_t             a_p;
        pos_t             b_p;
        pos_t             lo_p;
        pos_t             two_n;
        pos_t             mir;
        pos_t             q;
        logic [WIN_W-1:0] cnt_lo;
        logic [WIN_W-1:0] cnt_hi;
        logic [2:0]       pts;
        n_p   = pos_t'(job_n_reg);
        a_p   = pos_t'(job_k_reg) - pos_t'(job_hl_reg);
        b_p   = a_p + pos_t'(job_win_reg) - pos_t'(1);
        lo_p  = (job_n_reg > SEEN_W'(MAX_WINDOW - 1)) ? n_p - pos_t'(MAX_WINDOW - 1) : '0;
        two_n = n_p + n_p;
        mir   = two_n - lo_p;
        cnt_lo = span_count(a_p, b_p, -lo_p, lo_p);
        if (job_end_reg)
        begin
            cnt_lo = cnt_lo + span_count(a_p, b_p, POS_NINF, -mir)
                            + span_count(a_p, b_p, mir, POS_INF);
            cnt_hi = span_count(a_p, b_p, n_p, n_p) + span_count(a_p, b_p, -n_p, -n_p);
        end
        else
        begin
            cnt_hi = span_count(a_p, b_p, POS_NINF, -n_p) + span_count(a_p, b_p, n_p, POS_INF);
        end
        for (int d = 0; d < MAX_WINDOW; d++)
        begin
            q   = n_p - pos_t'(d);
            pts = 3'(in_span(a_p, b_p, q)) + 3'(in_span(a_p, b_p, -q));
            if (job_end_reg)
            begin
                pts = pts + 3'(in_span(a_p, b_p, two_n - q)) + 3'(in_span(a_p, b_p, q - two_n));
            end
            if (job_n_reg == '0)
            begin
                // A record of one sample: the whole window lands on it.
                s1_req_next.mult[d] = (d == 0) ? job_win_reg : '0;
            end
            else if (d == 0)
            begin
                s1_req_next.mult[d] = cnt_hi;
            end
            else if (q == lo_p)
            begin
                s1_req_next.mult[d] = cnt_lo;
            end
            else if (q > lo_p)
            begin
                s1_req_next.mult[d] = WIN_W'(pts);
            end
            else
            begin
                s1_req_next.mult[d] = '0;
            end
        end
        s1_req_next.vals     = history_reg;
        s1_req_next.half     = job_hl_reg;
        s1_req_next.last_out = job_last_reg && (job_rem_reg == REM_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WINDOW_RESET;
            seen_reg        <= '0;
            owed_reg        <= '0;
            job_rem_reg     <= '0;
            credit_reg      <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                window_size_reg <= window_size;
            end
            if (accept)
            begin
                seen_reg    <= item.last_in ? '0 : seen_inc;
                owed_reg    <= owed_next;
                job_rem_reg <= cnt_new;
            end
            else if (issue)
            begin
                job_rem_reg <= job_rem_reg - REM_W'(1);
            end
            if (issue && !pop)
            begin
                credit_reg <= credit_reg + FIFO_CNT_W'(1);
            end
            else if (pop && !issue)
            begin
                credit_reg <= credit_reg - FIFO_CNT_W'(1);
            end
            s1_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            history_reg  <= {history_reg[MAX_WINDOW-2:0], item.sample};
            job_n_reg    <= n_new;
            job_end_reg  <= item.last_in;
            job_win_reg  <= win_eff;
            job_hl_reg   <= hl_eff;
            job_k_reg    <= k_first;
            job_last_reg <= item.last_in;
        end
        else if (issue)
        begin
            job_k_reg <= job_k_reg + SEEN_W'(1);
        end
        if (issue)
        begin
            s1_req_reg <= s1_req_next;
        end
    end

    msmf_rank u_rank (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s1_valid_reg),
        .req       (s1_req_reg),
        .res_valid (rank_valid),
        .res       (rank_word)
    );

    msmf_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rank_valid),
        .push_word (rank_word),
        .pop_valid (result_valid),
        .pop_stall (result_stall),
        .pop_word  (result)
    );

endmodule
